// File: rtl/core/bitmap_pixel_to_rgba2222_macros.svh
// Assertion macros for the RGBA2222 pixel converter checker.
// No dependencies; included by the checker file.
`ifndef BITMAP_PIXEL_TO_RGBA2222_MACROS_SVH
`define BITMAP_PIXEL_TO_RGBA2222_MACROS_SVH

// Same-cycle implication, off while reset is held
`define BPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bitmap_pixel_to_rgba2222 check failed");

// Next-cycle implication, off while reset is held
`define BPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bitmap_pixel_to_rgba2222 check failed");

// Next-cycle implication, always active (used for reset behavior)
`define BPR_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bitmap_pixel_to_rgba2222 check failed");

`endif

// File: rtl/core/bprgba_pkg.sv
// Shared types, constants and helpers of the RGBA2222 pixel converter.
// No dependencies.
package bprgba_pkg;

    // Palette geometry
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int PAL_IDX_W = 8;
    localparam int PAL_ENT_W = 24;

    // Pixel modes
    localparam logic [1:0] MODE_INDEXED = 2'd0;
    localparam logic [1:0] MODE_DIRECT  = 2'd1;
    localparam logic [1:0] MODE_RGB555  = 2'd2;

    // Item opcodes
    localparam logic OP_CONVERT   = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_PIXEL_MODE = 3'd0;
    localparam logic [2:0] REG_RED_SEL    = 3'd1;
    localparam logic [2:0] REG_GREEN_SEL  = 3'd2;
    localparam logic [2:0] REG_BLUE_SEL   = 3'd3;
    localparam logic [2:0] REG_ALPHA_SEL  = 3'd4;

    // Register reset values
    localparam logic [1:0] RST_PIXEL_MODE = MODE_DIRECT;
    localparam logic [1:0] RST_RED_SEL    = 2'd2;
    localparam logic [1:0] RST_GREEN_SEL  = 2'd1;
    localparam logic [1:0] RST_BLUE_SEL   = 2'd0;
    localparam logic [2:0] RST_ALPHA_SEL  = 3'b111;

    // Result for an indexed pixel beyond the palette
    localparam logic [7:0] RES_OUT_OF_RANGE = 8'hC0;
    localparam logic [1:0] ALPHA_FULL       = 2'b11;

    // Palette write port
    typedef struct packed {
        logic                 en;
        logic [PAL_AW-1:0]    addr;
        logic [PAL_ENT_W-1:0] data;
    } pal_wr_t;

    // Top two bits of the byte at a position of a 32-bit word
    function automatic logic [1:0] byte_top2(input logic [31:0] word, input logic [1:0] pos);
        logic [1:0] r;
        unique case (pos)
            2'd0: r = word[7:6];
            2'd1: r = word[15:14];
            2'd2: r = word[23:22];
            2'd3: r = word[31:30];
            default: r = word[7:6];
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/bitmap_pixel_to_rgba2222.sv
// A convert item passes two register stages, stage one and the output register, on its
// way to the result port; a stalled result port holds it in the stage where it is.
// Items are taken one per cycle while the result port is not stalled; a palette write yields no result.
// The rate rests on the registered palette read port and the two-stage pipe.
// Reset (aresetn low, synchronous) clears the pipe and restores the registers;
// the palette is not cleared and holds undefined data until written.
module bitmap_pixel_to_rgba2222 (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_pixel_word,
    input  logic [7:0]  s_palette_index,
    input  logic [23:0] s_palette_entry,
    input  logic        s_last_pixel,
    // result item channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_rgba2222,
    output logic        m_last_out
);

    // Configuration registers
    logic [1:0] pixel_mode_reg;
    logic [1:0] red_sel_reg;
    logic [1:0] green_sel_reg;
    logic [1:0] blue_sel_reg;
    logic [2:0] alpha_sel_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    // Pipe stage one and output stage
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_use_pal_reg;
    logic       s1_idx_ok_reg;
    logic [7:0] s1_res_reg;
    logic       s1_last_reg;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg;
    logic       m_last_reg;

    logic       accept;
    logic       cvt;
    logic       advance;
    logic       idx_ok;
    logic       wr_ok;
    logic [7:0] res_direct;
    logic [7:0] res_555;
    logic [7:0] res_pre;
    logic [7:0] s1_res;
    logic [1:0] alpha_top;

    bprgba_pkg::pal_wr_t                  pal_wr;
    logic                                 pal_rd_en;
    logic [bprgba_pkg::PAL_ENT_W-1:0]     pal_rd_data;

    // Configuration write and read back
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_mode_reg <= bprgba_pkg::RST_PIXEL_MODE;
            red_sel_reg    <= bprgba_pkg::RST_RED_SEL;
            green_sel_reg  <= bprgba_pkg::RST_GREEN_SEL;
            blue_sel_reg   <= bprgba_pkg::RST_BLUE_SEL;
            alpha_sel_reg  <= bprgba_pkg::RST_ALPHA_SEL;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                bprgba_pkg::REG_PIXEL_MODE: pixel_mode_reg <= pwdata[1:0];
                bprgba_pkg::REG_RED_SEL:    red_sel_reg    <= pwdata[1:0];
                bprgba_pkg::REG_GREEN_SEL:  green_sel_reg  <= pwdata[1:0];
                bprgba_pkg::REG_BLUE_SEL:   blue_sel_reg   <= pwdata[1:0];
                bprgba_pkg::REG_ALPHA_SEL:  alpha_sel_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            bprgba_pkg::REG_PIXEL_MODE: prdata = {30'd0, pixel_mode_reg};
            bprgba_pkg::REG_RED_SEL:    prdata = {30'd0, red_sel_reg};
            bprgba_pkg::REG_GREEN_SEL:  prdata = {30'd0, green_sel_reg};
            bprgba_pkg::REG_BLUE_SEL:   prdata = {30'd0, blue_sel_reg};
            bprgba_pkg::REG_ALPHA_SEL:  prdata = {{29{alpha_sel_reg[2]}}, alpha_sel_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Handshake: stage one moves on when the output register is free or drains
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign cvt     = accept && (s_opcode == bprgba_pkg::OP_CONVERT);

    // Palette write and read, both at the accept edge so order is kept
    assign idx_ok = {1'b0, s_pixel_word[7:0]} <
                    (bprgba_pkg::PAL_IDX_W + 1)'(bprgba_pkg::PAL_DEPTH);
    assign wr_ok  = {1'b0, s_palette_index} <
                    (bprgba_pkg::PAL_IDX_W + 1)'(bprgba_pkg::PAL_DEPTH);

    assign pal_wr.en   = accept && (s_opcode == bprgba_pkg::OP_PAL_WRITE) && wr_ok;
    assign pal_wr.addr = s_palette_index[bprgba_pkg::PAL_AW-1:0];
    assign pal_wr.data = s_palette_entry;
    assign pal_rd_en   = cvt && (pixel_mode_reg == bprgba_pkg::MODE_INDEXED) && idx_ok;

    bprgba_palette u_palette (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd_en   (pal_rd_en),
        .rd_addr (s_pixel_word[bprgba_pkg::PAL_AW-1:0]),
        .rd_data (pal_rd_data)
    );

    // Direct and 555 conversion ahead of stage one
    assign alpha_top  = alpha_sel_reg[2] ? bprgba_pkg::ALPHA_FULL
                        : bprgba_pkg::byte_top2(s_pixel_word, alpha_sel_reg[1:0]);
    assign res_direct = {alpha_top,
                         bprgba_pkg::byte_top2(s_pixel_word, blue_sel_reg),
                         bprgba_pkg::byte_top2(s_pixel_word, green_sel_reg),
                         bprgba_pkg::byte_top2(s_pixel_word, red_sel_reg)};
    assign res_555    = {bprgba_pkg::ALPHA_FULL, s_pixel_word[4:3],
                         s_pixel_word[9:8], s_pixel_word[14:13]};
    assign res_pre    = (pixel_mode_reg == bprgba_pkg::MODE_RGB555) ? res_555 : res_direct;

    // Stage one: hold the item while the palette read completes
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (cvt) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cvt) begin
            s1_use_pal_reg <= (pixel_mode_reg == bprgba_pkg::MODE_INDEXED);
            s1_idx_ok_reg  <= idx_ok;
            s1_res_reg     <= res_pre;
            s1_last_reg    <= s_last_pixel;
        end
    end

    // Pack the palette entry: alpha full, then blue, green, red top bits
    always_comb begin
        priority if (!s1_use_pal_reg) begin
            s1_res = s1_res_reg;
        end else if (s1_idx_ok_reg) begin
            s1_res = {bprgba_pkg::ALPHA_FULL, pal_rd_data[7:6],
                      pal_rd_data[15:14], pal_rd_data[23:22]};
        end else begin
            s1_res = bprgba_pkg::RES_OUT_OF_RANGE;
        end
    end

    // Output register
    assign m_valid_next = advance ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_data_reg <= s1_res;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_rgba2222 = m_data_reg;
    assign m_last_out = m_last_reg;

endmodule

// File: rtl/core/bprgba_palette.sv
// Palette memory of the RGBA2222 pixel converter: one write port, one
// registered read port. Depends on bprgba_pkg.
module bprgba_palette (
    input  logic                                aclk,
    input  bprgba_pkg::pal_wr_t                 wr,
    input  logic                                rd_en,
    input  logic [bprgba_pkg::PAL_AW-1:0]       rd_addr,
    output logic [bprgba_pkg::PAL_ENT_W-1:0]    rd_data
);

    logic [bprgba_pkg::PAL_ENT_W-1:0] mem [bprgba_pkg::PAL_DEPTH];
    logic [bprgba_pkg::PAL_ENT_W-1:0] rd_data_reg;

    // Store entry
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read entry, hold data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/bprgba_checker.sv
// Port-level checks of the RGBA2222 pixel converter, bound to its top level.
// Depends on bitmap_pixel_to_rgba2222_macros.svh.
`include "bitmap_pixel_to_rgba2222_macros.svh"

module bprgba_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_rgba2222,
    input logic       m_last_out
);

    // A stalled result item stays put
    `BPR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rgba2222) && $stable(m_last_out))

    // Input backpressure only comes from a stalled output
    `BPR_ASSERT_IMP(a_ready_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // Reset empties the pipe and opens the input
    `BPR_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_valid && s_ready)

    // Configuration port never waits
    `BPR_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready)

endmodule

bind bitmap_pixel_to_rgba2222 bprgba_checker u_bprgba_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .pready     (pready),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_rgba2222 (m_rgba2222),
    .m_last_out (m_last_out)
);

// File: test/bitmap_pixel_to_rgba2222_checker.sv
// Result checker for the RGBA2222 pixel converter: follows register writes and
// palette loads, predicts each converted pixel and compares it with the output.
// Depends on bprgba_pkg for pixel modes, opcodes, register indexes and reset values.
module bitmap_pixel_to_rgba2222_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [31:0] s_pixel_word,
    input  logic [7:0]  s_palette_index,
    input  logic [23:0] s_palette_entry,
    input  logic        s_last_pixel,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_rgba2222,
    input  logic        m_last_out,
    output int          mismatch_count,
    output int          pending_count
);

    typedef struct packed {
        logic [7:0] rgba;
        logic       last;
    } pixel_result_t;

    pixel_result_t                    expected_pixels[$];
    logic [bprgba_pkg::PAL_ENT_W-1:0] palette_copy [bprgba_pkg::PAL_DEPTH];
    logic [1:0]                       pix_mode;
    logic [1:0]                       red_sel;
    logic [1:0]                       green_sel;
    logic [1:0]                       blue_sel;
    logic [2:0]                       alpha_sel;
    int                               n_mismatch = 0;
    int                               n_waiting = 0;

    assign mismatch_count = n_mismatch;
    assign pending_count  = n_waiting;

    // Top two bits of the byte at position pos
    function automatic logic [1:0] byte_msbs(input logic [31:0] word, input logic [1:0] pos);
        return word[{pos, 3'd6} +: 2];
    endfunction

    // Work out the converted byte under the current mode and positions
    function automatic logic [7:0] predict_rgba2222(input logic [31:0] word);
        logic [bprgba_pkg::PAL_ENT_W-1:0] entry;
        logic [4:0]                       red5;
        logic [4:0]                       green5;
        logic [4:0]                       blue5;
        logic [1:0]                       alpha;
        logic [7:0]                       result;
        case (pix_mode)
            bprgba_pkg::MODE_INDEXED: begin
                if (int'(word[7:0]) >= bprgba_pkg::PAL_DEPTH) begin
                    result = bprgba_pkg::RES_OUT_OF_RANGE;
                end else begin
                    entry  = palette_copy[word[7:0]];
                    result = {bprgba_pkg::ALPHA_FULL, entry[7:6], entry[15:14], entry[23:22]};
                end
            end
            bprgba_pkg::MODE_RGB555: begin
                red5   = word[14:10];
                green5 = word[9:5];
                blue5  = word[4:0];
                result = {bprgba_pkg::ALPHA_FULL, blue5[4:3], green5[4:3], red5[4:3]};
            end
            default: begin
                // unused mode 3 falls through to direct byte picking
                alpha  = alpha_sel[2] ? bprgba_pkg::ALPHA_FULL
                                      : byte_msbs(word, alpha_sel[1:0]);
                result = {alpha, byte_msbs(word, blue_sel), byte_msbs(word, green_sel),
                          byte_msbs(word, red_sel)};
            end
        endcase
        return result;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
        end
    endtask

    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            pix_mode  = bprgba_pkg::RST_PIXEL_MODE;
            red_sel   = bprgba_pkg::RST_RED_SEL;
            green_sel = bprgba_pkg::RST_GREEN_SEL;
            blue_sel  = bprgba_pkg::RST_BLUE_SEL;
            alpha_sel = bprgba_pkg::RST_ALPHA_SEL;
            expected_pixels.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    bprgba_pkg::REG_PIXEL_MODE: pix_mode  = pwdata[1:0];
                    bprgba_pkg::REG_RED_SEL:    red_sel   = pwdata[1:0];
                    bprgba_pkg::REG_GREEN_SEL:  green_sel = pwdata[1:0];
                    bprgba_pkg::REG_BLUE_SEL:   blue_sel  = pwdata[1:0];
                    bprgba_pkg::REG_ALPHA_SEL:  alpha_sel = pwdata[2:0];
                    default: ;
                endcase
            end
            // Load the palette copy or queue the predicted pixel
            if (s_valid && s_ready) begin
                if (s_opcode == bprgba_pkg::OP_PAL_WRITE) begin
                    if (int'(s_palette_index) < bprgba_pkg::PAL_DEPTH) begin
                        palette_copy[s_palette_index] = s_palette_entry;
                    end
                end else begin
                    want.rgba = predict_rgba2222(s_pixel_word);
                    want.last = s_last_pixel;
                    expected_pixels.push_back(want);
                end
            end
            // Compare each delivered pixel with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    flag_mismatch("unexpected result item", 8'hxx, m_rgba2222);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_rgba2222 !== want.rgba) begin
                        flag_mismatch("rgba2222", want.rgba, m_rgba2222);
                    end
                    if (m_last_out !== want.last) begin
                        flag_mismatch("last_out", {7'd0, want.last}, {7'd0, m_last_out});
                    end
                end
            end
        end
        n_waiting <= expected_pixels.size();
    end

endmodule

// File: test/bitmap_pixel_to_rgba2222_tb.sv
// Testbench top for the RGBA2222 pixel converter: drives directed and random
// pixel and palette items through several register settings, with random idling.
// Depends on bprgba_pkg, the converter and bitmap_pixel_to_rgba2222_checker.
module bitmap_pixel_to_rgba2222_tb;

    localparam int         RANDOM_PHASES  = 10;
    localparam int         PHASE_ITEMS    = 190;
    localparam int         HOLD_AT        = 900;
    localparam int         HOLD_LEN       = 250;
    localparam int         SETTLE_CYCLES  = 4;
    localparam logic [1:0] MODE_SPARE     = 2'd3;
    localparam logic [2:0] ALPHA_SEL_FULL = 3'b111;  // -1
    localparam logic [2:0] ALPHA_SEL_MIN  = 3'b100;  // -4

    logic        aclk;
    logic        aresetn         = 1'b0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [4:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_valid         = 1'b0;
    wire         s_ready;
    logic        s_opcode        = bprgba_pkg::OP_CONVERT;
    logic [31:0] s_pixel_word    = '0;
    logic [7:0]  s_palette_index = '0;
    logic [23:0] s_palette_entry = '0;
    logic        s_last_pixel    = 1'b0;
    wire         m_valid;
    logic        m_ready         = 1'b0;
    wire  [7:0]  m_rgba2222;
    wire         m_last_out;
    int          mismatch_count;
    int          pending_count;

    int          accepted_inputs = 0;
    logic        src_idle_on     = 1'b0;
    logic        sink_idle_on    = 1'b0;
    int          stall_left      = 0;
    int          hold_left       = 0;
    logic        hold_done       = 1'b0;
    logic [1:0]  cur_mode        = bprgba_pkg::RST_PIXEL_MODE;
    logic [7:0]  recent_index    = '0;
    logic [7:0]  loaded_indexes[$];
    logic        loaded [bprgba_pkg::PAL_DEPTH];

    bitmap_pixel_to_rgba2222 uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pixel_word    (s_pixel_word),
        .s_palette_index (s_palette_index),
        .s_palette_entry (s_palette_entry),
        .s_last_pixel    (s_last_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rgba2222      (m_rgba2222),
        .m_last_out      (m_last_out)
    );

    bitmap_pixel_to_rgba2222_checker u_pixel_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pixel_word    (s_pixel_word),
        .s_palette_index (s_palette_index),
        .s_palette_entry (s_palette_entry),
        .s_last_pixel    (s_last_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rgba2222      (m_rgba2222),
        .m_last_out      (m_last_out),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Count accepted input items to place the long output hold
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            accepted_inputs <= accepted_inputs + 1;
        end
    end

    // Result sink: one long hold once, random stall bursts otherwise
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && accepted_inputs >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN - 1;
            m_ready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one item, with an optional gap first, and hold it until accepted
    task automatic send_item(input logic op, input logic [31:0] word, input logic [7:0] idx,
                             input logic [23:0] ent, input logic last);
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_pixel_word    <= word;
        s_palette_index <= idx;
        s_palette_entry <= ent;
        s_last_pixel    <= last;
        if (op == bprgba_pkg::OP_PAL_WRITE) begin
            recent_index = idx;
            if (!loaded[idx]) begin
                loaded[idx] = 1'b1;
                loaded_indexes.push_back(idx);
            end
        end
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic convert_pixel(input logic [31:0] word, input logic last);
        send_item(bprgba_pkg::OP_CONVERT, word, 8'($urandom), 24'($urandom), last);
    endtask

    task automatic load_palette(input logic [7:0] idx, input logic [23:0] ent);
        send_item(bprgba_pkg::OP_PAL_WRITE, $urandom, idx, ent, 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and wait until every predicted pixel has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic set_registers(input logic [1:0] mode, input logic [1:0] red,
                                 input logic [1:0] green, input logic [1:0] blue,
                                 input logic [2:0] alpha);
        wait_idle();
        reg_write(bprgba_pkg::REG_PIXEL_MODE, {30'd0, mode});
        reg_write(bprgba_pkg::REG_RED_SEL,    {30'd0, red});
        reg_write(bprgba_pkg::REG_GREEN_SEL,  {30'd0, green});
        reg_write(bprgba_pkg::REG_BLUE_SEL,   {30'd0, blue});
        reg_write(bprgba_pkg::REG_ALPHA_SEL,  {29'd0, alpha});
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        cur_mode  = mode;
        @(posedge aclk);
    endtask

    // Mostly conversions; indexed pixels only point at loaded entries
    task automatic random_item();
        logic [31:0] word;
        word = $urandom;
        if ($urandom_range(0, 4) == 0) begin
            load_palette(8'($urandom), 24'($urandom));
        end else begin
            if (cur_mode == bprgba_pkg::MODE_INDEXED) begin
                if ($urandom_range(0, 3) == 0) begin
                    word[7:0] = recent_index;
                end else begin
                    word[7:0] = loaded_indexes[$urandom_range(0, loaded_indexes.size() - 1)];
                end
            end
            convert_pixel(word, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn     <= 1'b1;
        src_idle_on <= 1'b1;
        sink_idle_on <= 1'b1;
        @(posedge aclk);

        // Direct mode at reset settings: extremes, then palette loads
        convert_pixel(32'h0000_0000, 1'b0);
        convert_pixel(32'hFFFF_FFFF, 1'b1);
        convert_pixel(32'h40C0_8000, 1'b0);
        send_item(bprgba_pkg::OP_PAL_WRITE, 32'hFFFF_FFFF, 8'h00, 24'h00_0000, 1'b1);
        load_palette(8'hFF, 24'hFF_FFFF);
        load_palette(8'hA5, 24'h40_C080);
        load_palette(8'h5A, 24'hC0_4080);

        // Indexed mode: unused upper bits, back-to-back load and read, overwrite
        set_registers(bprgba_pkg::MODE_INDEXED, 2'd2, 2'd1, 2'd0, ALPHA_SEL_FULL);
        convert_pixel(32'hFFFF_FF00, 1'b0);
        convert_pixel(32'h0000_00FF, 1'b1);
        convert_pixel(32'h1234_56A5, 1'b0);
        load_palette(8'h5A, 24'h80_C040);
        convert_pixel(32'h0000_005A, 1'b0);
        load_palette(8'hA5, 24'h00_FF00);
        convert_pixel(32'hABCD_EFA5, 1'b1);

        // 555 mode: all fields set, only ignored bits set, alternating bits
        set_registers(bprgba_pkg::MODE_RGB555, 2'd2, 2'd1, 2'd0, ALPHA_SEL_FULL);
        convert_pixel(32'h0000_7FFF, 1'b0);
        convert_pixel(32'hFFFF_8000, 1'b0);
        convert_pixel(32'h0000_5294, 1'b1);

        // Unused mode acts as direct, with alpha taken from the top byte
        set_registers(MODE_SPARE, 2'd0, 2'd1, 2'd2, 3'd3);
        convert_pixel(32'hC080_4000, 1'b0);

        // Most negative alpha position forces full alpha
        set_registers(bprgba_pkg::MODE_DIRECT, 2'd2, 2'd1, 2'd0, ALPHA_SEL_MIN);
        convert_pixel(32'hFFFF_FFFF, 1'b0);
        convert_pixel(32'h0000_0000, 1'b1);

        // Random phases, extreme settings first; no idling in the last one
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_registers(bprgba_pkg::MODE_DIRECT, 2'd0, 2'd0, 2'd0, 3'd0);
                1: set_registers(bprgba_pkg::MODE_INDEXED, 2'd3, 2'd3, 2'd3, 3'd3);
                2: set_registers(bprgba_pkg::MODE_RGB555, 2'd3, 2'd2, 2'd1, ALPHA_SEL_MIN);
                3: set_registers(MODE_SPARE, 2'd1, 2'd3, 2'd2, 3'd2);
                default: set_registers(2'($urandom), 2'($urandom), 2'($urandom),
                                       2'($urandom), 3'($urandom));
            endcase
            if (p == RANDOM_PHASES - 1) begin
                src_idle_on  <= 1'b0;
                sink_idle_on <= 1'b0;
            end else begin
                src_idle_on  <= ($urandom_range(0, 2) != 0);
                sink_idle_on <= ($urandom_range(0, 2) != 0);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_item();
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Bound the run in case the block hangs
    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bprgba_pkg.sv
rtl/core/bprgba_palette.sv
rtl/core/bitmap_pixel_to_rgba2222.sv
rtl/core/bprgba_checker.sv
test/bitmap_pixel_to_rgba2222_checker.sv
test/bitmap_pixel_to_rgba2222_tb.sv
